// ----- sv/bvm_pkg.sv -----
// Shared types, codes and constants of the bytecode VM execute unit.
// Depends on nothing; the front end, back end, top level and bench import it.
`timescale 1ns / 1ps

package bvm_pkg;

	// Fixed sizes of the machine.
	localparam int MEM_DEPTH_C   = 4096;
	localparam int STACK_DEPTH_C = 16;
	localparam int DISP_WIDTH_C  = 64;
	localparam int DISP_HEIGHT_C = 32;
	localparam int NUM_REGS_C    = 16;
	localparam int FQ_DEPTH_C    = 2;

	// Reset value of the font base register.
	localparam logic [11:0] FONT_BASE_RST = 12'h050;

	// Command codes of an input transaction.
	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_MWR  = 2'd1;
	localparam logic [1:0] CMD_MRD  = 2'd2;
	localparam logic [1:0] CMD_ROW  = 2'd3;

	// Timer load codes of a result.
	localparam logic [1:0] TW_NONE  = 2'd0;
	localparam logic [1:0] TW_DELAY = 2'd1;
	localparam logic [1:0] TW_SOUND = 2'd2;

	// Input transaction.
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] opcode;
		logic [11:0] mem_address;
		logic [7:0]  mem_data;
		logic [4:0]  row_select;
		logic [15:0] key_mask;
		logic [7:0]  rnd_byte;
		logic [7:0]  delay_now;
	} in_t;

	// Result transaction.
	typedef struct packed {
		logic [11:0] next_pc;
		logic [15:0] index_value;
		logic [7:0]  read_byte;
		logic [63:0] row_bits;
		logic [1:0]  timer_write;
		logic [7:0]  timer_value;
		logic        waiting_key;
		logic        status;
	} out_t;

	// Operation class assigned by the front end.
	typedef enum logic [4:0] {
		K_MWR, K_MRD, K_ROW, K_BAD,
		K_CLS, K_RET, K_JP, K_CALL, K_SE, K_SNE, K_SER, K_LD, K_ADD, K_ALU,
		K_SNER, K_LDI, K_JPV, K_RND, K_DRW, K_SKP, K_SKNP,
		K_LDDT, K_WKEY, K_SDT, K_SST, K_ADDI, K_FONT, K_BCD, K_STO, K_LOD
	} kind_t;

	// Queue entry between front and back.
	typedef struct packed {
		kind_t kind;
		in_t   item;
	} qent_t;

	// Memory port request from the back end.
	typedef struct packed {
		logic        we;
		logic [11:0] waddr;
		logic [7:0]  wdata;
		logic [11:0] raddr;
	} mem_req_t;

endpackage

// ----- sv/bvm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module bvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/bvm_front.sv -----
// Front end: accepts input transactions, classifies them and queues them.
// Depends on bvm_pkg.
`timescale 1ns / 1ps

module bvm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  bvm_pkg::in_t  item,
	input  logic          deq,
	output logic          q_valid,
	output bvm_pkg::qent_t q_entry
);
	import bvm_pkg::*;

	localparam int PW = $clog2(FQ_DEPTH_C);

	qent_t            ent_q [FQ_DEPTH_C];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	kind_t            kind;
	logic [3:0]       hi;
	logic [7:0]       kk;
	logic             do_push, do_pop;

	// Classify the incoming transaction.
	always_comb begin
		hi = item.opcode[15:12];
		kk = item.opcode[7:0];
		kind = K_BAD;
		case (item.cmd)
			CMD_MWR: kind = K_MWR;
			CMD_MRD: kind = K_MRD;
			CMD_ROW: kind = K_ROW;
			default: begin
				case (hi)
					4'h0: kind = (kk == 8'hE0) ? K_CLS : ((kk == 8'hEE) ? K_RET : K_BAD);
					4'h1: kind = K_JP;
					4'h2: kind = K_CALL;
					4'h3: kind = K_SE;
					4'h4: kind = K_SNE;
					4'h5: kind = K_SER;
					4'h6: kind = K_LD;
					4'h7: kind = K_ADD;
					4'h8: begin
						case (item.opcode[3:0])
							4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: kind = K_ALU;
							default: kind = K_BAD;
						endcase
					end
					4'h9: kind = K_SNER;
					4'hA: kind = K_LDI;
					4'hB: kind = K_JPV;
					4'hC: kind = K_RND;
					4'hD: kind = K_DRW;
					4'hE: kind = (kk == 8'h9E) ? K_SKP : ((kk == 8'hA1) ? K_SKNP : K_BAD);
					default: begin
						case (kk)
							8'h07: kind = K_LDDT;
							8'h0A: kind = K_WKEY;
							8'h15: kind = K_SDT;
							8'h18: kind = K_SST;
							8'h1E: kind = K_ADDI;
							8'h29: kind = K_FONT;
							8'h33: kind = K_BCD;
							8'h55: kind = K_STO;
							8'h65: kind = K_LOD;
							default: kind = K_BAD;
						endcase
					end
				endcase
			end
		endcase
	end

	assign full    = (cnt_q == (PW+1)'(FQ_DEPTH_C));
	assign q_valid = (cnt_q != '0);
	assign q_entry = ent_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = deq && q_valid;

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(FQ_DEPTH_C-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(FQ_DEPTH_C-1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= '{kind: kind, item: item};
		end
	end

endmodule

// ----- sv/bvm_back.sv -----
// Back end: carries out queued transactions against the machine state and
// holds the result register. Depends on bvm_pkg; drives the main memory RAM.
`timescale 1ns / 1ps

module bvm_back #(
	parameter int STACK_DEPTH = bvm_pkg::STACK_DEPTH_C
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [11:0]       font_base,
	input  logic              q_valid,
	input  bvm_pkg::qent_t    q_entry,
	output logic              deq,
	output bvm_pkg::mem_req_t mem_req,
	input  logic [7:0]        mem_rdata,
	output logic              empty,
	input  logic              pop,
	output bvm_pkg::out_t     result
);
	import bvm_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_VX, ST_VY, ST_EXEC, ST_MWAIT, ST_DRAW_RD, ST_DRAW_WR,
		ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WR, ST_DONE
	} state_t;

	state_t         state_q;
	in_t            it_q;
	kind_t          kind_q;
	logic [7:0]     vx_q, vy_q;
	logic [11:0]    pc_q;
	logic [15:0]    idx_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]     gp_q [NUM_REGS_C];
	logic [11:0]    stk_q [STACK_DEPTH];
	logic [63:0]    frame_q [DISP_HEIGHT_C];
	logic [3:0]     cnt_q;
	logic           hit_q;
	logic [7:0]     rb_q, tv_q;
	logic [63:0]    bits_q;
	logic [1:0]     tw_q;
	logic           wk_q, st_q;
	out_t           out_q;
	logic           out_v_q;

	logic [3:0]     rx, ry, n, rsel, key_idx;
	logic [7:0]     gp_rd;
	logic [11:0]    pc_inc, madr;
	logic [SPW-1:0] sp_inc, sp_dec;
	logic [4:0]     drow;
	logic [63:0]    dmask, dline;
	logic [127:0]   drot;
	logic           dhit;
	logic [1:0]     hund;
	logic [7:0]     rem;
	logic [14:0]    tprod;
	logic [3:0]     tens, ones;
	logic [7:0]     bcd_digit;
	logic [8:0]     sum9;
	logic [7:0]     alu_res;
	logic           alu_flag, alu_fwe;
	logic           out_load;

	assign rx = it_q.opcode[11:8];
	assign ry = it_q.opcode[7:4];
	assign n  = it_q.opcode[3:0];

	// Single register read port, steered by the state.
	always_comb begin
		case (state_q)
			ST_VY:    rsel = (kind_q == K_JPV) ? 4'd0 : ry;
			ST_STORE: rsel = cnt_q;
			default:  rsel = rx;
		endcase
		gp_rd = gp_q[rsel];
	end

	// Address and pointer arithmetic with wrap.
	assign pc_inc = pc_q + 12'd2;
	assign madr   = idx_q[11:0] + {8'd0, cnt_q};
	assign sp_inc = (sp_q == SPW'(STACK_DEPTH-1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH-1) : sp_q - 1'b1;

	// Sprite row mask: the byte rotated to the horizontal position.
	always_comb begin
		drow  = vy_q[4:0] + {1'b0, cnt_q};
		dline = {mem_rdata, 56'd0};
		drot  = {dline, dline} >> vx_q[5:0];
		dmask = drot[63:0];
		dhit  = hit_q | (|(frame_q[drow] & dmask));
	end

	// Decimal digits of Vx; tens via a reciprocal multiply of the 7-bit remainder.
	always_comb begin
		hund  = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
		rem   = vx_q - 8'(hund * 8'd100);
		tprod = {8'd0, rem[6:0]} * 15'd205;
		tens  = tprod[14:11];
		ones  = 4'(rem - ({4'd0, tens} * 8'd10));
		case (cnt_q[1:0])
			2'd0:    bcd_digit = {6'd0, hund};
			2'd1:    bcd_digit = {4'd0, tens};
			default: bcd_digit = {4'd0, ones};
		endcase
	end

	// Highest pressed key.
	always_comb begin
		key_idx = 4'd0;
		for (int k = 0; k < 16; k++) begin
			if (it_q.key_mask[k]) begin
				key_idx = 4'(k);
			end
		end
	end

	// Arithmetic and logic group.
	always_comb begin
		sum9     = {1'b0, vx_q} + {1'b0, vy_q};
		alu_res  = vy_q;
		alu_flag = 1'b0;
		alu_fwe  = 1'b0;
		case (n)
			4'h0: alu_res = vy_q;
			4'h1: alu_res = vx_q | vy_q;
			4'h2: alu_res = vx_q & vy_q;
			4'h3: alu_res = vx_q ^ vy_q;
			4'h4: begin
				alu_res  = sum9[7:0];
				alu_flag = sum9[8];
				alu_fwe  = 1'b1;
			end
			4'h5: begin
				alu_res  = vx_q - vy_q;
				alu_flag = (vx_q >= vy_q);
				alu_fwe  = 1'b1;
			end
			4'h6: begin
				alu_res  = {1'b0, vx_q[7:1]};
				alu_flag = vx_q[0];
				alu_fwe  = 1'b1;
			end
			4'h7: begin
				alu_res  = vy_q - vx_q;
				alu_flag = (vy_q >= vx_q);
				alu_fwe  = 1'b1;
			end
			4'hE: begin
				alu_res  = {vx_q[6:0], 1'b0};
				alu_flag = vx_q[7];
				alu_fwe  = 1'b1;
			end
			default: alu_res = vy_q;
		endcase
	end

	// Memory port requests.
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = madr;
		mem_req.wdata = gp_rd;
		mem_req.raddr = madr;
		case (state_q)
			ST_EXEC: begin
				if (kind_q == K_MWR) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = it_q.mem_address;
					mem_req.wdata = it_q.mem_data;
				end
				if (kind_q == K_MRD) begin
					mem_req.raddr = it_q.mem_address;
				end
			end
			ST_BCD: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = bcd_digit;
			end
			ST_STORE: mem_req.we = 1'b1;
			default:  mem_req.we = 1'b0;
		endcase
	end

	assign deq      = (state_q == ST_IDLE) && q_valid;
	assign out_load = (state_q == ST_DONE) && (!out_v_q || pop);
	assign empty    = !out_v_q;
	assign result   = out_q;

	// Return stack writes; entries have no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && kind_q == K_CALL) begin
			stk_q[sp_q] <= pc_inc;
		end
	end

	// Sequencer, machine state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			it_q    <= '0;
			kind_q  <= K_BAD;
			vx_q    <= '0;
			vy_q    <= '0;
			pc_q    <= '0;
			idx_q   <= '0;
			sp_q    <= '0;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			rb_q    <= '0;
			bits_q  <= '0;
			tw_q    <= TW_NONE;
			tv_q    <= '0;
			wk_q    <= 1'b0;
			st_q    <= 1'b0;
			out_q   <= '0;
			out_v_q <= 1'b0;
			for (int r = 0; r < NUM_REGS_C; r++) begin
				gp_q[r] <= '0;
			end
			for (int r = 0; r < DISP_HEIGHT_C; r++) begin
				frame_q[r] <= '0;
			end
		end else begin
			if (pop && out_v_q && !out_load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						it_q    <= q_entry.item;
						kind_q  <= q_entry.kind;
						rb_q    <= '0;
						bits_q  <= '0;
						tw_q    <= TW_NONE;
						tv_q    <= '0;
						wk_q    <= 1'b0;
						st_q    <= 1'b0;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_VX;
					end
				end
				ST_VX: begin
					vx_q    <= gp_rd;
					state_q <= ST_VY;
				end
				ST_VY: begin
					vy_q    <= gp_rd;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					if (kind_q != K_MWR && kind_q != K_MRD && kind_q != K_ROW) begin
						pc_q <= pc_inc;
					end
					case (kind_q)
						K_MRD: state_q <= ST_MWAIT;
						K_ROW: bits_q <= frame_q[it_q.row_select];
						K_BAD: st_q <= 1'b1;
						K_CLS: begin
							for (int r = 0; r < DISP_HEIGHT_C; r++) begin
								frame_q[r] <= '0;
							end
						end
						K_RET: begin
							sp_q <= sp_dec;
							pc_q <= stk_q[sp_dec];
						end
						K_JP: pc_q <= it_q.opcode[11:0];
						K_CALL: begin
							sp_q <= sp_inc;
							pc_q <= it_q.opcode[11:0];
						end
						K_SE:   if (vx_q == it_q.opcode[7:0]) pc_q <= pc_q + 12'd4;
						K_SNE:  if (vx_q != it_q.opcode[7:0]) pc_q <= pc_q + 12'd4;
						K_SER:  if (vx_q == vy_q) pc_q <= pc_q + 12'd4;
						K_SNER: if (vx_q != vy_q) pc_q <= pc_q + 12'd4;
						K_LD:   gp_q[rx] <= it_q.opcode[7:0];
						K_ADD:  gp_q[rx] <= vx_q + it_q.opcode[7:0];
						K_ALU: begin
							gp_q[rx] <= alu_res;
							if (alu_fwe) begin
								gp_q[NUM_REGS_C-1] <= {7'd0, alu_flag};
							end
						end
						K_LDI: idx_q <= {4'd0, it_q.opcode[11:0]};
						K_JPV: pc_q <= it_q.opcode[11:0] + {4'd0, vy_q};
						K_RND: gp_q[rx] <= it_q.rnd_byte & it_q.opcode[7:0];
						K_DRW: begin
							if (n == 4'd0) begin
								gp_q[NUM_REGS_C-1] <= '0;
							end else begin
								state_q <= ST_DRAW_RD;
							end
						end
						K_SKP:  if (it_q.key_mask[vx_q[3:0]]) pc_q <= pc_q + 12'd4;
						K_SKNP: if (!it_q.key_mask[vx_q[3:0]]) pc_q <= pc_q + 12'd4;
						K_LDDT: gp_q[rx] <= it_q.delay_now;
						K_WKEY: begin
							if (it_q.key_mask != '0) begin
								gp_q[rx] <= {4'd0, key_idx};
							end else begin
								pc_q <= pc_q;
								wk_q <= 1'b1;
							end
						end
						K_SDT: begin
							tw_q <= TW_DELAY;
							tv_q <= vx_q;
						end
						K_SST: begin
							tw_q <= TW_SOUND;
							tv_q <= vx_q;
						end
						K_ADDI: idx_q <= idx_q + {8'd0, vx_q};
						K_FONT: idx_q <= {4'd0, font_base} + 16'(vx_q[3:0] * 8'd5);
						K_BCD:  state_q <= ST_BCD;
						K_STO:  state_q <= ST_STORE;
						K_LOD:  state_q <= ST_LOAD_RD;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_MWAIT: begin
					rb_q    <= mem_rdata;
					state_q <= ST_DONE;
				end
				ST_DRAW_RD: state_q <= ST_DRAW_WR;
				ST_DRAW_WR: begin
					frame_q[drow] <= frame_q[drow] ^ dmask;
					hit_q         <= dhit;
					cnt_q         <= cnt_q + 1'b1;
					if (cnt_q == n - 4'd1) begin
						gp_q[NUM_REGS_C-1] <= {7'd0, dhit};
						state_q            <= ST_DONE;
					end else begin
						state_q <= ST_DRAW_RD;
					end
				end
				ST_BCD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd2) begin
						state_q <= ST_DONE;
					end
				end
				ST_STORE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rx) begin
						state_q <= ST_DONE;
					end
				end
				ST_LOAD_RD: state_q <= ST_LOAD_WR;
				ST_LOAD_WR: begin
					gp_q[cnt_q] <= mem_rdata;
					cnt_q       <= cnt_q + 1'b1;
					state_q     <= (cnt_q == rx) ? ST_DONE : ST_LOAD_RD;
				end
				ST_DONE: begin
					if (out_load) begin
						out_q   <= '{next_pc: pc_q, index_value: idx_q, read_byte: rb_q,
							row_bits: bits_q, timer_write: tw_q, timer_value: tv_q,
							waiting_key: wk_q, status: st_q};
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/bytecode_vm_execute_unit.sv -----
// Top level of the bytecode VM execute unit: front queue, back executor,
// main memory RAM and the font base register. Depends on bvm_pkg and all modules.
`timescale 1ns / 1ps

// Each transaction passes a two-entry input queue and is then carried out by a
// sequencer that reads Vx and Vy through one register port before it executes.
// Most commands then go straight to the done state; a memory read waits for the
// registered RAM data, a sprite draw does one RAM read and one display update
// per sprite row, BCD writes three digits in turn, and Fx55 and Fx65 move one
// register per step through the single main memory port. The result register
// lets the next transaction start while a result waits.

module bytecode_vm_execute_unit #(
	parameter int STACK_DEPTH = bvm_pkg::STACK_DEPTH_C
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  bvm_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output bvm_pkg::out_t result,
	input  logic          cfg_we,
	input  logic [11:0]   cfg_data
);
	import bvm_pkg::*;

	logic        q_valid, deq;
	qent_t       q_entry;
	mem_req_t    mem_req;
	logic [7:0]  mem_rdata;
	logic [11:0] font_base_q;

	// Font base configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_base_q <= FONT_BASE_RST;
		end else if (cfg_we) begin
			font_base_q <= cfg_data;
		end
	end

	bvm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.deq     (deq),
		.q_valid (q_valid),
		.q_entry (q_entry)
	);

	bvm_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.font_base (font_base_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.deq       (deq),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	bvm_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH_C)
	) u_mem (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the bytecode VM execute unit: random and directed
// transactions are checked against an in-bench model of the machine state.
// Depends on bvm_pkg and bytecode_vm_execute_unit.
`timescale 1ns / 1ps

module tb_top;
	import bvm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	in_t item = '0;
	out_t result;
	logic cfg_we = 1'b0;
	logic [11:0] cfg_data = '0;

	bytecode_vm_execute_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Machine state as the bench expects it.
	logic [7:0]  vreg [16];
	logic [11:0] pc_m;
	logic [15:0] idx_m;
	logic [11:0] stk_m [16];
	logic        stk_ok [16];
	logic [3:0]  sp_m;
	logic [7:0]  mem_m [4096];
	logic [63:0] rows_m [32];
	logic [11:0] font_m;

	in_t  send_q [$];
	out_t result_q [$];
	int   errors = 0;
	int   tx_idle = 0;
	int   rx_idle = 0;
	int   rx_hold = 0;
	int   n_exec = 0;
	int   n_other = 0;

	// Computes the result of one transaction and updates the machine state.
	function automatic out_t step_machine(in_t t);
		out_t o;
		logic [3:0] x, y;
		logic [7:0] vx, vy, kk, ln;
		logic [11:0] nnn;
		logic [8:0] s;
		logic [5:0] xp;
		logic [4:0] yp, r;
		logic hit;
		logic [63:0] b;
		o = '0;
		x = t.opcode[11:8];
		y = t.opcode[7:4];
		kk = t.opcode[7:0];
		nnn = t.opcode[11:0];
		vx = vreg[x];
		vy = vreg[y];
		case (t.cmd)
			CMD_MWR: mem_m[t.mem_address] = t.mem_data;
			CMD_MRD: o.read_byte = mem_m[t.mem_address];
			CMD_ROW: o.row_bits = rows_m[t.row_select];
			default: begin
				pc_m = pc_m + 12'd2;
				case (t.opcode[15:12])
					4'h0: begin
						if (kk == 8'hE0) begin
							for (int i = 0; i < 32; i++) rows_m[i] = '0;
						end else if (kk == 8'hEE) begin
							sp_m = sp_m - 4'd1;
							pc_m = stk_m[sp_m];
						end else o.status = 1'b1;
					end
					4'h1: pc_m = nnn;
					4'h2: begin
						stk_m[sp_m] = pc_m;
						stk_ok[sp_m] = 1'b1;
						sp_m = sp_m + 4'd1;
						pc_m = nnn;
					end
					4'h3: if (vx == kk) pc_m = pc_m + 12'd2;
					4'h4: if (vx != kk) pc_m = pc_m + 12'd2;
					4'h5: if (vx == vy) pc_m = pc_m + 12'd2;
					4'h6: vreg[x] = kk;
					4'h7: vreg[x] = vx + kk;
					4'h8: begin
						case (t.opcode[3:0])
							4'h0: vreg[x] = vy;
							4'h1: vreg[x] = vx | vy;
							4'h2: vreg[x] = vx & vy;
							4'h3: vreg[x] = vx ^ vy;
							4'h4: begin
								s = {1'b0, vx} + {1'b0, vy};
								vreg[x] = s[7:0];
								vreg[15] = {7'd0, s[8]};
							end
							4'h5: begin
								vreg[x] = vx - vy;
								vreg[15] = {7'd0, vx >= vy};
							end
							4'h6: begin
								vreg[x] = vx >> 1;
								vreg[15] = {7'd0, vx[0]};
							end
							4'h7: begin
								vreg[x] = vy - vx;
								vreg[15] = {7'd0, vy >= vx};
							end
							4'hE: begin
								vreg[x] = vx << 1;
								vreg[15] = {7'd0, vx[7]};
							end
							default: o.status = 1'b1;
						endcase
					end
					4'h9: if (vx != vy) pc_m = pc_m + 12'd2;
					4'hA: idx_m = {4'd0, nnn};
					4'hB: pc_m = nnn + {4'd0, vreg[0]};
					4'hC: vreg[x] = t.rnd_byte & kk;
					4'hD: begin
						// Sprite rows wrap on both display edges; any cleared pixel sets VF.
						xp = vx[5:0];
						yp = vy[4:0];
						hit = 1'b0;
						for (int i = 0; i < t.opcode[3:0]; i++) begin
							ln = mem_m[idx_m[11:0] + 12'(i)];
							r = yp + 5'(i);
							for (int j = 0; j < 8; j++) begin
								if (ln[7 - j]) begin
									b = 64'd1 << (63 - 6'(xp + 6'(j)));
									if (rows_m[r] & b) hit = 1'b1;
									rows_m[r] ^= b;
								end
							end
						end
						vreg[15] = {7'd0, hit};
					end
					4'hE: begin
						if (kk == 8'h9E) begin
							if (t.key_mask[vx[3:0]]) pc_m = pc_m + 12'd2;
						end else if (kk == 8'hA1) begin
							if (!t.key_mask[vx[3:0]]) pc_m = pc_m + 12'd2;
						end else o.status = 1'b1;
					end
					default: begin
						case (kk)
							8'h07: vreg[x] = t.delay_now;
							8'h0A: begin
								if (t.key_mask != 0) begin
									for (int i = 0; i < 16; i++)
										if (t.key_mask[i]) vreg[x] = 8'(i);
								end else begin
									pc_m = pc_m - 12'd2;
									o.waiting_key = 1'b1;
								end
							end
							8'h15: begin
								o.timer_write = TW_DELAY;
								o.timer_value = vx;
							end
							8'h18: begin
								o.timer_write = TW_SOUND;
								o.timer_value = vx;
							end
							8'h1E: idx_m = idx_m + {8'd0, vx};
							8'h29: idx_m = {4'd0, font_m} + {12'd0, vx[3:0]} * 16'd5;
							8'h33: begin
								mem_m[idx_m[11:0]] = 8'(vx / 100);
								mem_m[idx_m[11:0] + 12'd1] = 8'((vx / 10) % 10);
								mem_m[idx_m[11:0] + 12'd2] = 8'(vx % 10);
							end
							8'h55: for (int i = 0; i <= x; i++) mem_m[idx_m[11:0] + 12'(i)] = vreg[i];
							8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem_m[idx_m[11:0] + 12'(i)];
							default: o.status = 1'b1;
						endcase
					end
				endcase
			end
		endcase
		o.next_pc = pc_m;
		o.index_value = idx_m;
		return o;
	endfunction

	// Queues one transaction with random side fields and records its result.
	// A non-negative keys argument fixes the pressed-key mask.
	task automatic send(logic [1:0] cmd, logic [15:0] op, int keys = -1);
		in_t t;
		t.cmd = cmd;
		t.opcode = op;
		t.mem_address = 12'($urandom);
		t.mem_data = 8'($urandom);
		t.row_select = 5'($urandom);
		t.key_mask = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
		t.rnd_byte = 8'($urandom);
		t.delay_now = 8'($urandom);
		if (keys >= 0) t.key_mask = 16'(keys);
		// A return from a stack entry never pushed is turned into a call.
		if (cmd == CMD_EXEC && op[15:12] == 4'h0 && op[7:0] == 8'hEE && !stk_ok[sp_m - 4'd1])
			t.opcode = {4'h2, 12'($urandom)};
		if (cmd == CMD_EXEC) n_exec++;
		else n_other++;
		result_q.push_back(step_machine(t));
		send_q.push_back(t);
	endtask

	// Draws one opcode, mostly well-formed with random operands.
	function automatic logic [15:0] rand_op();
		logic [15:0] r;
		logic [7:0] fk [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
		logic [3:0] an [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
		r = 16'($urandom);
		case ($urandom_range(19))
			0: r = {8'h00, ($urandom_range(1) ? 8'hE0 : 8'hEE)};
			1: r[7:0] = 8'hEE;
			2, 3: r[15:12] = 4'h8;
			4: r = {r[15:12], r[11:4], an[$urandom_range(8)]} | 16'h8000;
			5, 6: r = {4'hF, r[11:8], fk[$urandom_range(8)]};
			7: r = {4'hE, r[11:8], ($urandom_range(1) ? 8'h9E : 8'hA1)};
			8, 9: r[15:12] = 4'hD;
			10: r = {4'h6, r[11:0]};
			default: ;
		endcase
		if ($urandom_range(3) == 0 && r[15:12] == 4'h8) r[3:0] = an[$urandom_range(8)];
		return r;
	endfunction

	// Waits until every queued transaction has been sent and answered.
	task automatic drain();
		while (send_q.size() != 0 || result_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_font(logic [11:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		font_m = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Input side: drop the head on acceptance, offer the next at the falling edge.
	always @(posedge clk)
		if (push && !full) void'(send_q.pop_front());

	always @(negedge clk) begin
		if (send_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
			push <= 1'b1;
			item <= send_q[0];
		end else push <= 1'b0;
	end

	// Result side: compare each accepted transaction with the oldest expectation.
	task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
		end
	endtask

	always @(posedge clk) begin
		out_t e;
		if (pop && !empty) begin
			if (result_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $time, result);
			end else begin
				e = result_q.pop_front();
				check_field("next_pc", e.next_pc, result.next_pc);
				check_field("index_value", e.index_value, result.index_value);
				check_field("read_byte", e.read_byte, result.read_byte);
				check_field("row_bits", e.row_bits, result.row_bits);
				check_field("timer_write", e.timer_write, result.timer_write);
				check_field("timer_value", e.timer_value, result.timer_value);
				check_field("waiting_key", e.waiting_key, result.waiting_key);
				check_field("status", e.status, result.status);
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			pop <= 1'b0;
		end else pop <= ($urandom_range(99) >= rx_idle);
	end

	// Stimulus sequence.
	initial begin
		for (int i = 0; i < 16; i++) begin
			vreg[i] = '0;
			stk_m[i] = '0;
			stk_ok[i] = 1'b0;
		end
		for (int i = 0; i < 32; i++) rows_m[i] = '0;
		for (int i = 0; i < 4096; i++) mem_m[i] = '0;
		pc_m = '0;
		idx_m = '0;
		sp_m = '0;
		font_m = FONT_BASE_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill memory in blocks of sixteen bytes so that every later read sees a
		// written byte; two registers get fresh random values before each block.
		for (int blk = 0; blk < 256; blk++) begin
			send(CMD_EXEC, {4'hA, 8'(blk), 4'h0});
			send(CMD_EXEC, {4'hC, 4'($urandom), 8'hFF});
			send(CMD_EXEC, {4'hC, 4'($urandom), 8'hFF});
			send(CMD_EXEC, 16'hFF55);
		end
		drain();

		// Directed: extremes, flags, wraps, stack, keys and unknown opcodes.
		send(CMD_EXEC, 16'h60FF); send(CMD_EXEC, 16'h61FF); send(CMD_EXEC, 16'h8014);
		send(CMD_EXEC, 16'h8F15); send(CMD_EXEC, 16'h8107); send(CMD_EXEC, 16'h8F06);
		send(CMD_EXEC, 16'h81FE); send(CMD_EXEC, 16'h7EFF); send(CMD_EXEC, 16'hBFFF);
		send(CMD_EXEC, 16'h2FFE); send(CMD_EXEC, 16'h00EE); send(CMD_EXEC, 16'hAFFF);
		send(CMD_EXEC, 16'hF133); send(CMD_EXEC, 16'hFF55); send(CMD_EXEC, 16'hFF65);
		send(CMD_EXEC, 16'hD000); send(CMD_EXEC, 16'h623F); send(CMD_EXEC, 16'h631F);
		send(CMD_EXEC, 16'hD23F); send(CMD_EXEC, 16'hD23F);
		send(CMD_EXEC, 16'hF00A, 0); send(CMD_EXEC, 16'hF00A, 16'h0280);
		send(CMD_ROW, 16'h0000); send(CMD_EXEC, 16'h0123); send(CMD_EXEC, 16'hF0FF);
		send(CMD_EXEC, 16'hF029);
		drain();

		// Random phases under different idling and font base settings.
		for (int ph = 0; ph < 3; ph++) begin
			write_font(ph == 0 ? 12'd0 : ph == 1 ? 12'hFFF : 12'($urandom));
			tx_idle = (ph == 0) ? 14 : (ph == 1) ? 65 : 0;
			rx_idle = (ph == 0) ? 65 : (ph == 1) ? 14 : 0;
			if (ph == 2) rx_hold = 400;
			for (int i = 0; i < 240; i++) begin
				case ($urandom_range(9))
					0: send(CMD_MWR, 16'($urandom));
					1: send(CMD_MRD, 16'($urandom));
					2: send(CMD_ROW, 16'($urandom));
					default: send(CMD_EXEC, rand_op());
				endcase
			end
			drain();
		end
		write_font(FONT_BASE_RST);
		send(CMD_EXEC, 16'hFA29);
		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d executed opcodes and %0d memory and display commands,",
			n_exec, n_other);
		$display("over three font base settings and three idling mixes.");
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/bvm_pkg.sv
sv/bvm_ram.sv
sv/bvm_front.sv
sv/bvm_back.sv
sv/bytecode_vm_execute_unit.sv
bench/tb_top.sv
